// ===== rtl/bfnp_pkg.sv =====
// shared types and constants of the bitmap set-bit search block
package bfnp_pkg;

  localparam int WORD_BITS = 32;
  localparam int OFF_W     = 5;   // bit offset inside a word
  localparam int CNT_W     = 11;  // bit count register
  localparam int IDX_W     = 10;  // reported bit index
  localparam int POS_W     = 12;  // signed search position
  localparam int WIDX_W    = 5;   // word index of a write or read
  localparam int SCAN_W    = 6;   // word index reached by a search
  localparam int SPOS_W    = 14;  // signed working width of a start position

  localparam logic [CNT_W-1:0] BIT_COUNT_RST = 11'd1024;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_NEXT  = 2'd2,
    OP_PREV  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/bfnp_ram.sv =====
// generic single-write, single-read ram with registered read data
module bfnp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/bitmap_find_next_prev_set_top.sv =====
// bitmap word store with find-next and find-prev set-bit search
// a search walks one ram word per cycle, up to MAX_BITS/32 words (rounded up); a new
//   item is taken only once the last result has moved into the output register
// reset: synchronous active-low; afterwards a clearing pass writes zero to every word,
//   one word a cycle, and no word is taken meanwhile
module bitmap_find_next_prev_set_top #(
  parameter int MAX_BITS = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_opcode,
  input  logic [4:0]          in_word_index,
  input  logic [31:0]         in_word_data,
  input  logic signed [11:0]  in_position,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_found,
  output logic [9:0]          out_bit_index,
  output logic [31:0]         out_read_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [10:0]         cfg_data
);

  localparam int NUM_WORDS = (MAX_BITS + bfnp_pkg::WORD_BITS - 1) / bfnp_pkg::WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int CW        = bfnp_pkg::CNT_W;
  localparam int SW        = bfnp_pkg::SPOS_W;
  localparam int WW        = bfnp_pkg::SCAN_W;
  localparam int OW        = bfnp_pkg::OFF_W;
  localparam int IW        = bfnp_pkg::IDX_W;

  function automatic logic [4:0] low_bit(input logic [31:0] t);
    logic [31:0] iso;
    logic [4:0]  r;
    iso = t & (~t + 32'd1);
    r   = '0;
    for (int i = 0; i < 32; i++) begin
      if (iso[i]) begin
        r = r | 5'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [4:0] high_bit(input logic [31:0] t);
    logic [31:0] rev;
    for (int i = 0; i < 32; i++) begin
      rev[i] = t[31-i];
    end
    return ~low_bit(rev);
  endfunction

  bfnp_pkg::state_t state_r, state_nxt;
  bfnp_pkg::op_t    in_op;

  logic [CW-1:0] bit_count_r;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [WW-1:0] w_r, w_nxt;
  logic [OW-1:0] off_r, off_nxt;
  logic          first_r, first_nxt;
  logic          dir_next_r, dir_next_nxt;
  logic          rd_ok_r, rd_ok_nxt;
  logic          res_found_r, res_found_nxt;
  logic [IW-1:0] res_idx_r, res_idx_nxt;
  logic [31:0]   res_data_r, res_data_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_found_r, out_found_nxt;
  logic [IW-1:0] out_idx_r, out_idx_nxt;
  logic [31:0]   out_data_r, out_data_nxt;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;

  logic                 acc, out_free, wr_ok;
  logic [CW-1:0]        cnt_eff;
  logic signed [SW-1:0] pos_x, bn, sp, cm1, cnt_x, start;
  logic                 start_ok;
  logic [31:0]          mask, masked;
  logic                 hit, last_word, scan_found, scan_done;
  logic [4:0]           bitpos;
  logic [CW-1:0]        hit_idx;
  logic [11:0]          nstart;

  assign in_op     = bfnp_pkg::op_t'(in_opcode);
  assign acc       = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign wr_ok     = int'(in_word_index) < NUM_WORDS;
  assign cfg_ready = 1'b1;

  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_bit_index = out_idx_r;
  assign out_read_data = out_data_r;

  // searches never see bits past the bitmap itself
  assign cnt_eff = (int'(bit_count_r) > MAX_BITS) ? CW'(MAX_BITS) : bit_count_r;

  // start bit and first word of a search
  always_comb begin
    pos_x = SW'(in_position);
    cnt_x = signed'(SW'(cnt_eff));
    bn    = pos_x + SW'(1);
    if (bn < 0) begin
      bn = '0;
    end
    sp  = pos_x - SW'(1);
    cm1 = cnt_x - SW'(1);
    if (sp > cm1) begin
      sp = cm1;
    end
    if (in_op == bfnp_pkg::OP_NEXT) begin
      start    = bn;
      start_ok = bn < cnt_x;
    end else begin
      start    = sp;
      start_ok = sp >= 0;
    end
  end

  // evaluate the word that arrived from the ram
  always_comb begin
    if (dir_next_r) begin
      mask = first_r ? (32'hFFFF_FFFF << off_r) : 32'hFFFF_FFFF;
    end else begin
      mask = first_r ? (32'hFFFF_FFFF >> (5'd31 - off_r)) : 32'hFFFF_FFFF;
    end
    masked  = ram_rdata & mask;
    hit     = |masked;
    bitpos  = dir_next_r ? low_bit(masked) : high_bit(masked);
    hit_idx = {w_r, bitpos};
    nstart  = {7'(w_r) + 7'd1, 5'd0};
    if (dir_next_r) begin
      scan_found = hit && (hit_idx < cnt_eff);
      last_word  = nstart >= 12'(cnt_eff);
    end else begin
      scan_found = hit;
      last_word  = (w_r == '0);
    end
    scan_done = hit || last_word;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bfnp_pkg::ST_CLEAR: begin
        if (clr_r == AW'(NUM_WORDS - 1)) begin
          state_nxt = bfnp_pkg::ST_IDLE;
        end
      end
      bfnp_pkg::ST_IDLE: begin
        if (acc) begin
          case (in_op)
            bfnp_pkg::OP_WRITE: state_nxt = bfnp_pkg::ST_DONE;
            bfnp_pkg::OP_READ:  state_nxt = bfnp_pkg::ST_READ;
            default:            state_nxt = start_ok ? bfnp_pkg::ST_SCAN : bfnp_pkg::ST_DONE;
          endcase
        end
      end
      bfnp_pkg::ST_READ: state_nxt = bfnp_pkg::ST_DONE;
      bfnp_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = bfnp_pkg::ST_DONE;
        end
      end
      bfnp_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = bfnp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bfnp_pkg::ST_CLEAR;
    endcase
  end

  // fsm outputs: handshake and ram port control
  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = AW'(in_word_index);
    ram_wdata = in_word_data;
    ram_re    = 1'b0;
    ram_raddr = AW'(in_word_index);
    case (state_r)
      bfnp_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
      end
      bfnp_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (in_op)
            bfnp_pkg::OP_WRITE: ram_we = wr_ok;
            bfnp_pkg::OP_READ:  ram_re = 1'b1;
            default: begin
              ram_re    = 1'b1;
              ram_raddr = AW'(start[10:5]);
            end
          endcase
        end
      end
      bfnp_pkg::ST_SCAN: begin
        // fetch the following word while this one is examined
        ram_re    = 1'b1;
        ram_raddr = dir_next_r ? AW'(w_r + WW'(1)) : AW'(w_r - WW'(1));
      end
      default: begin
      end
    endcase
  end

  // datapath next values
  always_comb begin
    clr_nxt       = clr_r + AW'(1);
    w_nxt         = w_r;
    off_nxt       = off_r;
    first_nxt     = first_r;
    dir_next_nxt  = dir_next_r;
    rd_ok_nxt     = rd_ok_r;
    res_found_nxt = res_found_r;
    res_idx_nxt   = res_idx_r;
    res_data_nxt  = res_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;
    out_idx_nxt   = out_idx_r;
    out_data_nxt  = out_data_r;
    case (state_r)
      bfnp_pkg::ST_IDLE: begin
        if (acc) begin
          w_nxt         = start[10:5];
          off_nxt       = start[4:0];
          first_nxt     = 1'b1;
          dir_next_nxt  = (in_op == bfnp_pkg::OP_NEXT);
          rd_ok_nxt     = wr_ok;
          res_found_nxt = 1'b0;
          res_idx_nxt   = '0;
          res_data_nxt  = '0;
        end
      end
      bfnp_pkg::ST_READ: begin
        res_data_nxt = rd_ok_r ? ram_rdata : '0;
      end
      bfnp_pkg::ST_SCAN: begin
        first_nxt = 1'b0;
        w_nxt     = dir_next_r ? (w_r + WW'(1)) : (w_r - WW'(1));
        if (scan_done) begin
          res_found_nxt = scan_found;
          res_idx_nxt   = scan_found ? hit_idx[IW-1:0] : '0;
        end
      end
      bfnp_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_idx_nxt   = res_idx_r;
          out_data_nxt  = res_data_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfnp_pkg::ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      bit_count_r <= bfnp_pkg::BIT_COUNT_RST;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        bit_count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    w_r         <= w_nxt;
    off_r       <= off_nxt;
    first_r     <= first_nxt;
    dir_next_r  <= dir_next_nxt;
    rd_ok_r     <= rd_ok_nxt;
    res_found_r <= res_found_nxt;
    res_idx_r   <= res_idx_nxt;
    res_data_r  <= res_data_nxt;
    out_found_r <= out_found_nxt;
    out_idx_r   <= out_idx_nxt;
    out_data_r  <= out_data_nxt;
  end

  bfnp_ram #(
    .WIDTH (bfnp_pkg::WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // no word is taken while the clearing pass runs
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bfnp_pkg::ST_CLEAR) |-> in_stall)
    else $error("input taken during clearing pass");

  // a finished result reaches the output register once it is free
  a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bfnp_pkg::ST_DONE && out_free) |=> out_valid_r)
    else $error("finished result not delivered");

  // a search hit never carries read data
  a_found_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |-> (out_data_r == '0))
    else $error("search result carries read data");

  // the scan pointer stays inside the bitmap
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bfnp_pkg::ST_SCAN) |-> (int'(w_r) < NUM_WORDS))
    else $error("scan word beyond bitmap");

endmodule

// ===== verif/bitmap_search_checker.sv =====
// checker for the bitmap search block: mirrors the bitmap, predicts each result word and compares
`timescale 1ns / 1ps

module bitmap_search_checker #(
  parameter int MAX_BITS = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [1:0]          in_opcode,
  input  logic [4:0]          in_word_index,
  input  logic [31:0]         in_word_data,
  input  logic signed [11:0]  in_position,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic                out_found,
  input  logic [9:0]          out_bit_index,
  input  logic [31:0]         out_read_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [10:0]         cfg_data,
  output int                  fail_count,
  output int                  outstanding
);

  localparam int NUM_WORDS =
    (MAX_BITS + bfnp_pkg::WORD_BITS - 1) / bfnp_pkg::WORD_BITS;

  typedef struct {
    logic                           found;
    logic [bfnp_pkg::IDX_W-1:0]     bit_index;
    logic [bfnp_pkg::WORD_BITS-1:0] read_data;
  } search_result_t;

  logic [bfnp_pkg::WORD_BITS-1:0] bitmap_mirror [NUM_WORDS];
  logic [bfnp_pkg::CNT_W-1:0]     count_mirror;
  search_result_t                 expected_results [$];
  int                             errors;

  // searches never see past the bitmap, whatever the register holds
  function automatic int visible_bits();
    int c;
    c = count_mirror;
    if (c > MAX_BITS) c = MAX_BITS;
    return c;
  endfunction

  function automatic logic bit_at(int b);
    return bitmap_mirror[b / bfnp_pkg::WORD_BITS][b % bfnp_pkg::WORD_BITS];
  endfunction

  function automatic int find_set_above(int from);
    int lim;
    int b;
    lim = visible_bits();
    b = (from + 1 < 0) ? 0 : from + 1;
    while (b < lim) begin
      if (bit_at(b)) return b;
      b++;
    end
    return -1;
  endfunction

  // start clamped to count-1 so last never reports a bit at the count
  function automatic int find_set_below(int from);
    int lim;
    int s;
    lim = visible_bits();
    s = from - 1;
    if (s > lim - 1) s = lim - 1;
    while (s >= 0) begin
      if (bit_at(s)) return s;
      s--;
    end
    return -1;
  endfunction

  function automatic search_result_t predict_result(bfnp_pkg::op_t op, logic [4:0] widx,
                                                    logic [31:0] data,
                                                    logic signed [11:0] pos);
    search_result_t r;
    int hit;
    r.found = 1'b0;
    r.bit_index = '0;
    r.read_data = '0;
    hit = -1;
    case (op)
      bfnp_pkg::OP_WRITE: if (widx < NUM_WORDS) bitmap_mirror[widx] = data;
      bfnp_pkg::OP_READ:  if (widx < NUM_WORDS) r.read_data = bitmap_mirror[widx];
      bfnp_pkg::OP_NEXT:  hit = find_set_above(int'(pos));
      bfnp_pkg::OP_PREV:  hit = find_set_below(int'(pos));
      default: begin
      end
    endcase
    if (hit >= 0) begin
      r.found = 1'b1;
      r.bit_index = bfnp_pkg::IDX_W'(hit);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    search_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_WORDS; i++) bitmap_mirror[i] = '0;
      count_mirror = bfnp_pkg::BIT_COUNT_RST;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) count_mirror = cfg_data;
      if (in_valid && !in_stall)
        expected_results.push_back(predict_result(bfnp_pkg::op_t'(in_opcode), in_word_index,
                                                  in_word_data, in_position));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result word", out_read_data, 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_found !== want.found)
            report_mismatch("found", 32'(out_found), 32'(want.found));
          if (out_bit_index !== want.bit_index)
            report_mismatch("bit_index", 32'(out_bit_index), 32'(want.bit_index));
          if (out_read_data !== want.read_data)
            report_mismatch("read_data", out_read_data, want.read_data);
        end
      end
    end
    outstanding <= expected_results.size();
    fail_count  <= errors;
  end

endmodule

// ===== verif/bitmap_find_next_prev_set_top_tb.sv =====
// testbench top for the bitmap search block: stimulus, output stalls, watchdog and verdict
`timescale 1ns / 1ps

module bitmap_find_next_prev_set_top_tb;

  localparam int MAX_BITS       = 1024;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int BLOCK_ITEMS    = 130;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic [1:0]         in_opcode = '0;
  logic [4:0]         in_word_index = '0;
  logic [31:0]        in_word_data = '0;
  logic signed [11:0] in_position = '0;
  logic               out_stall = 1'b0;
  logic               cfg_valid = 1'b0;
  logic [10:0]        cfg_data = '0;
  logic               in_stall;
  logic               out_valid;
  logic               out_found;
  logic [9:0]         out_bit_index;
  logic [31:0]        out_read_data;
  logic               cfg_ready;

  int   fail_count;
  int   outstanding;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_requests = 0;
  int   holds_done = 0;
  int   quiet_cycles = 0;
  int   count_now = 1024;
  int   n_writes = 0;
  int   n_reads = 0;
  int   n_searches = 0;
  int   n_settings = 0;

  always #5 clk = ~clk;

  bitmap_find_next_prev_set_top #(.MAX_BITS(MAX_BITS)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_word_index(in_word_index), .in_word_data(in_word_data), .in_position(in_position),
    .out_valid(out_valid), .out_stall(out_stall), .out_found(out_found),
    .out_bit_index(out_bit_index), .out_read_data(out_read_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  bitmap_search_checker #(.MAX_BITS(MAX_BITS)) search_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_word_index(in_word_index), .in_word_data(in_word_data), .in_position(in_position),
    .out_valid(out_valid), .out_stall(out_stall), .out_found(out_found),
    .out_bit_index(out_bit_index), .out_read_data(out_read_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  // result side: random stalls, or one long hold when asked
  always begin
    @(posedge clk);
    if (holds_done != hold_requests) begin
      holds_done++;
      out_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
    end
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(bfnp_pkg::op_t op, logic [4:0] widx, logic [31:0] data,
                           logic signed [11:0] pos);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_word_index <= widx;
    in_word_data  <= data;
    in_position   <= pos;
    do @(posedge clk); while (in_stall);
    case (op)
      bfnp_pkg::OP_WRITE: n_writes++;
      bfnp_pkg::OP_READ:  n_reads++;
      default:            n_searches++;
    endcase
  endtask

  // sender pauses until every result is back, then lets the block settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_count(logic [10:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    count_now = v;
    n_settings++;
  endtask

  task automatic send_random();
    int                 pick;
    bfnp_pkg::op_t      op;
    logic [31:0]        d;
    logic signed [11:0] p;
    pick = $urandom_range(0, 99);
    if (pick < 25)      op = bfnp_pkg::OP_WRITE;
    else if (pick < 37) op = bfnp_pkg::OP_READ;
    else if (pick < 68) op = bfnp_pkg::OP_NEXT;
    else                op = bfnp_pkg::OP_PREV;
    // plenty of empty words so searches walk a long way
    case ($urandom_range(0, 6))
      0, 1:    d = '0;
      2:       d = 32'h1 << $urandom_range(0, 31);
      3:       d = $urandom & $urandom & $urandom;
      4:       d = '1;
      default: d = $urandom;
    endcase
    case ($urandom_range(0, 9))
      0:       p = 12'($urandom);
      1:       p = 12'hFFF;
      2:       p = 12'(count_now);
      3:       p = 12'($urandom_range(0, 32) * 32 + $urandom_range(0, 2) - 1);
      default: p = 12'($urandom_range(0, 1025) - 1);
    endcase
    send_word(op, 5'($urandom_range(0, 31)), d, p);
  endtask

  initial begin
    logic [10:0] count_plan [15];
    count_plan = '{11'd1, 11'd1024, 11'd32, 11'd33, 11'd1023, 11'd0, 11'd0, 11'd2047,
                   11'd64, 11'd31, 11'd0, 11'd1025, 11'd500, 11'd1, 11'd1024};
    count_plan[5]  = 11'($urandom_range(2, 1023));
    count_plan[6]  = 11'd0;
    count_plan[10] = 11'($urandom_range(1025, 2047));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // empty bitmap: first and last both miss
    send_word(bfnp_pkg::OP_READ,  5'd0,  32'd0, 12'sd0);
    send_word(bfnp_pkg::OP_NEXT,  5'd0,  32'd0, 12'hFFF);           // -1
    send_word(bfnp_pkg::OP_PREV,  5'd0,  32'd0, 12'd1024);
    send_word(bfnp_pkg::OP_WRITE, 5'd0,  32'h0000_0001, 12'sd0);
    send_word(bfnp_pkg::OP_WRITE, 5'd31, 32'h8000_0000, 12'sd0);
    send_word(bfnp_pkg::OP_WRITE, 5'd5,  32'hFFFF_FFFF, 12'sd0);
    send_word(bfnp_pkg::OP_NEXT,  5'd0,  32'd0, 12'hFFF);
    send_word(bfnp_pkg::OP_NEXT,  5'd0,  32'd0, 12'h800);           // most negative start
    send_word(bfnp_pkg::OP_NEXT,  5'd0,  32'd0, 12'sd0);
    send_word(bfnp_pkg::OP_PREV,  5'd0,  32'd0, 12'd1024);
    send_word(bfnp_pkg::OP_PREV,  5'd0,  32'd0, 12'h7FF);
    send_word(bfnp_pkg::OP_PREV,  5'd0,  32'd0, 12'sd0);            // start below zero
    send_word(bfnp_pkg::OP_PREV,  5'd0,  32'd0, 12'sd1);
    send_word(bfnp_pkg::OP_NEXT,  5'd0,  32'd0, 12'd1023);
    send_word(bfnp_pkg::OP_NEXT,  5'd0,  32'd0, 12'h7FF);
    send_word(bfnp_pkg::OP_READ,  5'd31, 32'd0, 12'sd0);
    send_word(bfnp_pkg::OP_WRITE, 5'd5,  32'd0, 12'sd0);
    send_word(bfnp_pkg::OP_PREV,  5'd0,  32'd0, 12'd1023);          // walks every word
    // bit 1023 stays stored but falls outside a short count
    set_count(11'd100);
    send_word(bfnp_pkg::OP_NEXT,  5'd0,  32'd0, 12'sd0);
    send_word(bfnp_pkg::OP_READ,  5'd31, 32'd0, 12'sd0);
    set_count(11'd0);
    send_word(bfnp_pkg::OP_NEXT,  5'd0,  32'd0, 12'hFFF);
    send_word(bfnp_pkg::OP_PREV,  5'd0,  32'd0, 12'd1024);
    set_count(11'd2047);
    send_word(bfnp_pkg::OP_PREV,  5'd0,  32'd0, 12'h7FF);
    set_count(11'd1);
    send_word(bfnp_pkg::OP_NEXT,  5'd0,  32'd0, 12'hFFF);
    send_word(bfnp_pkg::OP_PREV,  5'd0,  32'd0, 12'h7FF);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 69;
        end
        1: begin
          send_idle_pct = 69;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int blk = 0; blk < 5; blk++) begin
        set_count(count_plan[ph * 5 + blk]);
        // hold the result side while the sender keeps pushing, so the block backs up
        if (ph == 2 && blk == 1) hold_requests++;
        repeat (BLOCK_ITEMS) send_random();
      end
    end

    drain();
    $display("covered %0d writes, %0d reads and %0d searches over %0d bit-count settings,",
             n_writes, n_reads, n_searches, n_settings);
    $display("with each side idling in turn, a no-idle stretch and one long result hold");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
